// ----- rtl/core/cfb_pkg.sv -----
// Package: shared types and constants for the command frame builder.
`timescale 1ns / 1ps
`default_nettype none

package cfb_pkg;

    localparam logic [7:0] START_BYTE = 8'd13;
    localparam logic [7:0] EXT_MARK   = 8'hFF;
    localparam int         CMD_SHIFT  = 3;

    localparam logic ACT_START = 1'b0;
    localparam logic ACT_DATA  = 1'b1;

    localparam int PLAN_DEPTH = 5;
    localparam int CNT_W      = $clog2(PLAN_DEPTH + 1);

    typedef struct packed {
        logic       action;
        logic [7:0] command;
        logic       extended;
        logic [7:0] length;
        logic [7:0] data_byte;
    } cfb_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       frame_end;
        logic       run_last;
    } cfb_out_t;

    // bytes[0] goes out first; count is the number of valid bytes
    typedef struct packed {
        logic [PLAN_DEPTH-1:0][7:0] bytes;
        logic [CNT_W-1:0]           count;
        logic                       closes;
    } cfb_plan_t;

endpackage

`default_nettype wire

// ----- rtl/core/cfb_planner.sv -----
// Frame state and per-transfer byte plan.
`timescale 1ns / 1ps
`default_nettype none

module cfb_planner (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  wire cfb_pkg::cfb_in_t  item,
    output cfb_pkg::cfb_plan_t     plan
);
    import cfb_pkg::*;

    logic       frame_open_reg, frame_open_next;
    logic [7:0] bytes_left_reg, bytes_left_next;
    logic [7:0] running_sum_reg, running_sum_next;

    logic [7:0] hdr;
    logic [7:0] sum_norm;
    logic [7:0] sum_ext;
    logic [7:0] sum_data;

    assign hdr      = (item.command << CMD_SHIFT) + item.length;
    assign sum_norm = START_BYTE + hdr;
    assign sum_ext  = START_BYTE + EXT_MARK + item.command + item.length;
    assign sum_data = running_sum_reg + item.data_byte;

    always_comb
    begin
        plan             = '0;
        frame_open_next  = frame_open_reg;
        bytes_left_next  = bytes_left_reg;
        running_sum_next = running_sum_reg;
        if (item.action == ACT_START)
        begin
            plan.bytes[0] = START_BYTE;
            if (item.extended)
            begin
                plan.bytes[1] = EXT_MARK;
                plan.bytes[2] = item.command;
                plan.bytes[3] = item.length;
                plan.count    = CNT_W'(4);
                running_sum_next = sum_ext;
            end
            else
            begin
                plan.bytes[1] = hdr;
                plan.count    = CNT_W'(2);
                running_sum_next = sum_norm;
            end
            frame_open_next = 1'b1;
            bytes_left_next = item.length;
            if (item.length == 8'd0)
            begin
                if (item.extended)
                    plan.bytes[4] = sum_ext;
                else
                    plan.bytes[2] = sum_norm;
                plan.count       = plan.count + CNT_W'(1);
                plan.closes      = 1'b1;
                frame_open_next  = 1'b0;
                running_sum_next = 8'd0;
            end
        end
        else if (frame_open_reg && (bytes_left_reg != 8'd0))
        begin
            plan.bytes[0]    = item.data_byte;
            plan.count       = CNT_W'(1);
            bytes_left_next  = bytes_left_reg - 8'd1;
            running_sum_next = sum_data;
            if (bytes_left_reg == 8'd1)
            begin
                plan.bytes[1]    = sum_data;
                plan.count       = CNT_W'(2);
                plan.closes      = 1'b1;
                frame_open_next  = 1'b0;
                running_sum_next = 8'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_open_reg  <= 1'b0;
            bytes_left_reg  <= 8'd0;
            running_sum_reg <= 8'd0;
        end
        else if (accept)
        begin
            frame_open_reg  <= frame_open_next;
            bytes_left_reg  <= bytes_left_next;
            running_sum_reg <= running_sum_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/cfb_serializer.sv -----
// Plan register and output register: shifts planned bytes out one per cycle while out_ready is not holding the output.
`timescale 1ns / 1ps
`default_nettype none

module cfb_serializer (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               load,
    input  wire cfb_pkg::cfb_plan_t plan,
    output logic                    free,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output cfb_pkg::cfb_out_t       out_item
);
    import cfb_pkg::*;

    logic [PLAN_DEPTH-1:0][7:0] bytes_reg;
    logic [CNT_W-1:0]           left_reg;
    logic                       closes_reg;
    logic                       out_valid_reg;
    cfb_out_t                   out_reg;

    logic emit;
    logic last;

    assign emit      = (left_reg != '0) && (!out_valid_reg || out_ready);
    assign last      = (left_reg == CNT_W'(1));
    assign free      = (left_reg == '0) || (emit && last);
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load && (plan.count != '0))
                left_reg <= plan.count;
            else if (emit)
                left_reg <= left_reg - CNT_W'(1);

            if (emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && (plan.count != '0))
        begin
            bytes_reg  <= plan.bytes;
            closes_reg <= plan.closes;
        end
        else if (emit)
            bytes_reg <= {8'd0, bytes_reg[PLAN_DEPTH-1:1]};

        if (emit)
        begin
            out_reg.out_byte  <= bytes_reg[0];
            out_reg.frame_end <= closes_reg && last;
            out_reg.run_last  <= last;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/command_frame_builder.sv -----
// Top level of the command frame builder.
`timescale 1ns / 1ps
`default_nettype none

// Builds serial command frames one byte per output transfer. A start
// transfer emits 13 and the header (one byte normal, three extended) and,
// for a zero length, the checksum; a data transfer emits its byte and,
// after the last counted byte, the checksum. An input transfer produces up
// to five bytes, and the next is accepted as its last byte enters the
// single output register; data bytes stream at one per cycle while the
// output is not stalled. Data outside an open frame produces no output.

module command_frame_builder (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire cfb_pkg::cfb_in_t in_item,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output cfb_pkg::cfb_out_t     out_item
);
    import cfb_pkg::*;

    logic      accept;
    logic      free;
    cfb_plan_t plan;

    assign in_ready = free;
    assign accept   = in_valid && free;

    cfb_planner u_planner (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (in_item),
        .plan   (plan)
    );

    cfb_serializer u_serializer (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .plan      (plan),
        .free      (free),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

endmodule

`default_nettype wire

// ----- test/cfb_checker.sv -----
// Checker: predicts command frame bytes from input transfers and compares output transfers.
`timescale 1ns / 1ps

module cfb_checker (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic              in_ready,
    input  wire cfb_pkg::cfb_in_t  in_item,
    input  wire logic              out_valid,
    input  wire logic              out_ready,
    input  wire cfb_pkg::cfb_out_t out_item,
    output int                     fail_count,
    output int                     pending
);
    import cfb_pkg::*;

    cfb_out_t   frame_bytes_q[$];
    logic       frame_open;
    logic [7:0] bytes_left;
    logic [7:0] frame_sum;
    int         fails = 0;
    int         waiting = 0;

    assign fail_count = fails;
    assign pending    = waiting;

    task automatic emit_byte(input logic [7:0] b, input logic is_end);
        cfb_out_t r;
        r.out_byte  = b;
        r.frame_end = is_end;
        r.run_last  = 1'b0;
        frame_bytes_q.push_back(r);
        frame_sum = frame_sum + b;
    endtask

    task automatic close_frame();
        emit_byte(frame_sum, 1'b1);
        frame_open = 1'b0;
        bytes_left = 8'd0;
        frame_sum  = 8'd0;
    endtask

    task automatic predict_bytes(input cfb_in_t it);
        int         depth_before;
        logic [7:0] hdr;
        cfb_out_t   tail;
        depth_before = frame_bytes_q.size();
        if (it.action == ACT_START)
        begin
            frame_sum = 8'd0;
            emit_byte(START_BYTE, 1'b0);
            if (!it.extended)
            begin
                hdr = it.command << CMD_SHIFT;
                hdr = hdr + it.length;
                emit_byte(hdr, 1'b0);
            end
            else
            begin
                emit_byte(EXT_MARK, 1'b0);
                emit_byte(it.command, 1'b0);
                emit_byte(it.length, 1'b0);
            end
            frame_open = 1'b1;
            bytes_left = it.length;
            if (bytes_left == 8'd0)
                close_frame();
        end
        else if (frame_open && bytes_left != 8'd0)
        begin
            emit_byte(it.data_byte, 1'b0);
            bytes_left = bytes_left - 8'd1;
            if (bytes_left == 8'd0)
                close_frame();
        end
        if (frame_bytes_q.size() > depth_before)
        begin
            tail = frame_bytes_q[$];
            tail.run_last = 1'b1;
            frame_bytes_q[$] = tail;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        cfb_out_t want;
        if (!rst_n)
        begin
            frame_bytes_q.delete();
            frame_open = 1'b0;
            bytes_left = 8'd0;
            frame_sum  = 8'd0;
        end
        else
        begin
            if (in_valid && in_ready)
                predict_bytes(in_item);
            if (out_valid && out_ready)
            begin
                if (frame_bytes_q.size() == 0)
                begin
                    $error("unexpected output transfer: out_byte %0h", out_item.out_byte);
                    fails++;
                end
                else
                begin
                    want = frame_bytes_q.pop_front();
                    if (out_item.out_byte !== want.out_byte)
                    begin
                        $error("out_byte expected %0h actual %0h",
                               want.out_byte, out_item.out_byte);
                        fails++;
                    end
                    if (out_item.frame_end !== want.frame_end)
                    begin
                        $error("frame_end expected %0b actual %0b",
                               want.frame_end, out_item.frame_end);
                        fails++;
                    end
                    if (out_item.run_last !== want.run_last)
                    begin
                        $error("run_last expected %0b actual %0b",
                               want.run_last, out_item.run_last);
                        fails++;
                    end
                end
            end
        end
        waiting = frame_bytes_q.size();
    end

endmodule

// ----- test/tb_command_frame_builder.sv -----
// Testbench top: drives the command frame builder and reports the verdict.
`timescale 1ns / 1ps

module tb_command_frame_builder;
    import cfb_pkg::*;

    localparam int HOLD_CYCLES = 300;
    localparam int QUIET_LIMIT = 3000;
    localparam int PHASE_ITEMS = 12;

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     in_valid  = 1'b0;
    logic     in_ready;
    cfb_in_t  in_item   = '0;
    logic     out_valid;
    logic     out_ready = 1'b0;
    cfb_out_t out_item;

    int   fail_count;
    int   pending;
    int   idle_pct     = 0;
    int   stall_pct    = 0;
    logic hold_req     = 1'b0;
    int   frame_items  = 0;
    int   quiet_cycles = 0;

    always #10 clk = ~clk;

    command_frame_builder i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    cfb_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_item   (out_item),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // entered and left at a falling edge
    task automatic offer(input cfb_in_t it);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_start(input logic [7:0] cmd, input logic ext, input logic [7:0] len);
        cfb_in_t it;
        it.action    = ACT_START;
        it.command   = cmd;
        it.extended  = ext;
        it.length    = len;
        it.data_byte = 8'($urandom);
        offer(it);
    endtask

    task automatic send_data(input logic [7:0] b);
        cfb_in_t it;
        it.action    = ACT_DATA;
        it.command   = 8'($urandom);
        it.extended  = 1'($urandom);
        it.length    = 8'($urandom);
        it.data_byte = b;
        offer(it);
    endtask

    task automatic send_payload(input int n);
        for (int i = 0; i < n; i++)
            send_data(8'($urandom));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
    endtask

    task automatic send_random_frame();
        int kind;
        int len;
        int ndata;
        kind = $urandom_range(99);
        if (kind < 55)
        begin
            len = $urandom_range(7);
            send_start(8'($urandom_range(31)), 1'b0, 8'(len));
            send_payload(len);
            frame_items += len + 1;
        end
        else if (kind < 80)
        begin
            len = $urandom_range(7);
            send_start(8'($urandom), 1'b1, 8'(len));
            send_payload(len);
            frame_items += len + 1;
        end
        else if (kind < 92)
        begin
            // open frame left short, abandoned by the next start
            len   = $urandom_range(255, 1);
            ndata = $urandom_range((len < 4) ? len - 1 : 3);
            send_start(8'($urandom), 1'($urandom), 8'(len));
            send_payload(ndata);
            frame_items += ndata + 1;
        end
        else
        begin
            send_payload($urandom_range(3, 1));
        end
    endtask

    // receiver
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles + 1 >= QUIET_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial
    begin
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_data(8'hA5);
        send_start(8'd0, 1'b0, 8'd0);
        send_data(8'h00);
        send_start(8'd31, 1'b0, 8'd7);
        send_data(8'hFF);
        send_data(8'h00);
        send_data(8'h80);
        send_data(8'h01);
        send_data(8'h7F);
        send_data(8'h55);
        send_data(8'hAA);
        send_start(8'hFF, 1'b0, 8'hFF);
        send_data(8'hFF);
        send_data(8'h00);
        send_start(8'hFF, 1'b1, 8'd0);
        send_start(8'd0, 1'b1, 8'd1);
        send_data(8'hFF);
        send_data(8'h12);
        send_start(8'hAA, 1'b1, 8'd3);
        send_data(8'h3C);
        send_start(8'd5, 1'b0, 8'd2);
        send_data(8'hC3);
        send_data(8'h0F);
        send_start(8'd20, 1'b0, 8'd9);
        drain();

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct  = 72;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct  = 0;
                    stall_pct = 72;
                end
                default:
                begin
                    idle_pct  = 23;
                    stall_pct = 23;
                end
            endcase
            if (phase == 0)
            begin
                hold_req = 1'b1;
                for (int f = 0; f < 2; f++)
                begin
                    send_start(8'($urandom_range(31)), 1'b0, 8'd7);
                    send_payload(7);
                end
                drain();
                send_start(8'($urandom), 1'b1, 8'd24);
                send_payload(24);
            end
            frame_items = 0;
            while (frame_items < PHASE_ITEMS)
                send_random_frame();
            drain();
        end

        repeat (20) @(negedge clk);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
